@@ rtl/itcf_pkg.sv @@
// Shared types and constants for the IMU tilt complementary filter.
// Holds the angle type, update kinds, register indexes and the CORDIC arctangent table.
// No dependencies.
package itcf_pkg;

   localparam int INT_FRAC = 16;
   localparam int ANGLE_W  = 25;

   typedef logic signed [ANGLE_W-1:0] angle_type;

   // 180 and 90 degrees in 1/65536 degree
   localparam angle_type HALF_TURN = 25'sd11796480;
   localparam angle_type NINETY    = 25'sd5898240;
   localparam logic signed [63:0] HALF_TURN_WIDE = 64'sd11796480;

   typedef enum logic [1:0] {
      KIND_FIRST  = 2'd0,
      KIND_RELOAD = 2'd1,
      KIND_BLEND  = 2'd2
   } update_kind_type;

   localparam logic [1:0] CSR_BLEND_WEIGHT = 2'd0;
   localparam logic [1:0] CSR_MAX_GAP_US   = 2'd1;
   localparam logic [1:0] CSR_GYRO_GAIN    = 2'd2;

   // atan(2^-i) in 1/65536 degree
   function automatic logic [22:0] atan_lut(input logic [4:0] idx);
      logic [22:0] v;
      unique case (idx)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117304;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         5'd20: v = 23'd4;
         5'd21: v = 23'd2;
         5'd22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

   // saturate to +-180 degrees
   function automatic angle_type clamp_angle(input logic signed [63:0] v);
      angle_type r;
      if (v > HALF_TURN_WIDE) begin
         r = HALF_TURN;
      end else if (v < -HALF_TURN_WIDE) begin
         r = -HALF_TURN;
      end else begin
         r = ANGLE_W'(v);
      end
      return r;
   endfunction

endpackage

@@ rtl/itcf_cordic.sv @@
// Iterative CORDIC in vectoring mode: atan2(y, x) in 1/65536 degree, one step per cycle.
// Depends on itcf_pkg for the angle type, the arctangent table and the clamp.
module itcf_cordic #(
   parameter int ITERATIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  itcf_pkg::angle_type x_in,
   input  itcf_pkg::angle_type y_in,
   output logic                done,
   output itcf_pkg::angle_type angle
);

   localparam int CNT_W = $clog2(ITERATIONS);
   localparam int XY_W  = 27;
   localparam int Z_W   = 26;

   typedef enum logic {C_IDLE, C_RUN} cordic_state_type;

   cordic_state_type           state_ff;
   logic signed [XY_W-1:0]     x_ff, y_ff, x0, y0, xi, yi, xs, ys, x_nx, y_nx;
   logic signed [Z_W-1:0]      z_ff, z0, z_nx, atan_s;
   logic [CNT_W-1:0]           iter_ff;
   logic                       zero_ff;
   logic                       done_ff;
   itcf_pkg::angle_type        angle_ff;

   assign xi = XY_W'(x_in);
   assign yi = XY_W'(y_in);

   // move the vector into the right half plane first
   always_comb begin
      if (xi < 0) begin
         if (yi >= 0) begin
            x0 = yi;
            y0 = -xi;
            z0 = Z_W'(itcf_pkg::NINETY);
         end else begin
            x0 = -yi;
            y0 = xi;
            z0 = -Z_W'(itcf_pkg::NINETY);
         end
      end else begin
         x0 = xi;
         y0 = yi;
         z0 = '0;
      end
   end

   assign xs     = x_ff >>> iter_ff;
   assign ys     = y_ff >>> iter_ff;
   assign atan_s = signed'(Z_W'(itcf_pkg::atan_lut(5'(iter_ff))));

   always_comb begin
      if (y_ff > 0) begin
         x_nx = x_ff + ys;
         y_nx = y_ff - xs;
         z_nx = z_ff + atan_s;
      end else begin
         x_nx = x_ff - ys;
         y_nx = y_ff + xs;
         z_nx = z_ff - atan_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  x_ff     <= x0;
                  y_ff     <= y0;
                  z_ff     <= z0;
                  zero_ff  <= (x_in == '0) && (y_in == '0);
                  iter_ff  <= '0;
                  state_ff <= C_RUN;
               end
            end
            C_RUN: begin
               x_ff    <= x_nx;
               y_ff    <= y_nx;
               z_ff    <= z_nx;
               iter_ff <= iter_ff + CNT_W'(1);
               if (iter_ff == CNT_W'(ITERATIONS - 1)) begin
                  done_ff  <= 1'b1;
                  angle_ff <= zero_ff ? '0 : itcf_pkg::clamp_angle(64'(z_nx));
                  state_ff <= C_IDLE;
               end
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

@@ rtl/imu_tilt_complementary_filter_top.sv @@
// Top level of the IMU tilt complementary filter: sequencer, shared multiplier, sqrt and divider.
// Depends on itcf_pkg and itcf_cordic.
//
// One sample at a time runs through a small sequencer around one shared 27x27 multiplier:
// S_SQ0 and S_SQ1 form ay^2+az^2, a bit-pair square root follows, then the CORDIC unit
// runs for pitch and for roll. A blended update adds, per axis, the gyro step multiplies
// S_G0 to S_G2, a setup state, an eight-digit divide by 10^6 by reciprocal multiplication,
// a step state and the blend states S_BL0 to S_BL2. req_ready is high only between samples.
// The result sits in an output register, so the next sample can be taken while the previous
// result waits for rsp_ready; a sample that finishes while that register is still full waits
// until it drains. Configuration writes are taken only while idle with no sample offered.
// Angles are signed, in 1/2^ANGLE_FRAC_BITS degree, saturated to +-180 degrees.
module imu_tilt_complementary_filter_top #(
   parameter int ANGLE_FRAC_BITS   = 8,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic        [31:0] req_time_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_filt_pitch,
   output logic signed [16:0] rsp_filt_roll,
   output logic signed [16:0] rsp_tilt_pitch,
   output logic signed [16:0] rsp_tilt_roll,
   output logic        [1:0]  rsp_update_kind,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [23:0] csr_wdata
);

   localparam int OUT_SHIFT  = itcf_pkg::INT_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [25:0] OUT_ROUND = 26'sd1 <<< (OUT_SHIFT - 1);
   localparam int SQRT_STEPS = 24;
   localparam int DIV_DIGITS = 8;
   localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
   localparam logic [22:0] DIV_RECIP    = 23'd4398047;
   localparam logic [63:0] DIV_ROUND    = 64'd500000;

   typedef enum logic [4:0] {
      S_IDLE, S_SQ0, S_SQ1, S_SQRT, S_TP_START, S_TP_WAIT, S_TR_START, S_TR_WAIT,
      S_DECIDE, S_G0, S_G1, S_G2, S_DIV_INIT, S_DIV, S_DIV_SUB, S_STEP, S_BL0, S_BL1, S_BL2,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [15:0]                blend_weight_ff;
   logic [23:0]                max_gap_ff;
   logic [23:0]                gyro_gain_ff;

   logic signed [15:0]         ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic [23:0]                dt_ff;
   itcf_pkg::update_kind_type  kind_ff;
   logic signed [63:0]         acc_ff;
   logic [39:0]                p1_ff;
   logic [47:0]                sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [19:0]                div_rem_ff;
   logic [43:0]                div_num_ff;
   logic [7:0]                 div_digit_ff;
   logic [5:0]                 cnt_ff;
   logic                       axis_ff;
   itcf_pkg::angle_type        tp_ff, tr_ff, gest_ff, filt_pitch_ff, filt_roll_ff;
   logic [31:0]                last_time_ff;
   logic                       have_prev_ff;

   logic                       rsp_valid_ff;
   logic [16:0]                rsp_fp_ff, rsp_fr_ff, rsp_tp_ff, rsp_tr_ff;
   logic [1:0]                 rsp_kind_ff;

   logic signed [26:0]         mul_a, mul_b;
   logic signed [53:0]         mul_p;
   logic signed [15:0]         rate;
   logic [15:0]                rate_mag;
   itcf_pkg::angle_type        cur_t, cur_f;
   logic [31:0]                dt_full, sumsq;
   logic [47:0]                sq_trial;
   logic                       sq_ge;
   logic [27:0]                div_trial;
   logic [63:0]                div_n;
   logic [44:0]                q_round;
   logic signed [37:0]         q_s, step_s, gsum;
   logic signed [63:0]         bl;
   logic                       cordic_start, cordic_done;
   itcf_pkg::angle_type        cordic_x, cordic_y, cordic_angle;

   function automatic logic [16:0] out_angle(input itcf_pkg::angle_type v);
      logic signed [25:0] r;
      r = 26'(v) + OUT_ROUND;
      return 17'(r >>> OUT_SHIFT);
   endfunction

   assign rate     = axis_ff ? gx_ff : gy_ff;
   assign rate_mag = rate[15] ? 16'(-rate) : 16'(rate);
   assign cur_t    = axis_ff ? tr_ff : tp_ff;
   assign cur_f    = axis_ff ? filt_roll_ff : filt_pitch_ff;

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         S_SQ0: begin
            mul_a = 27'(ay_ff);
            mul_b = 27'(ay_ff);
         end
         S_SQ1: begin
            mul_a = 27'(az_ff);
            mul_b = 27'(az_ff);
         end
         S_G0: begin
            mul_a = 27'(rate_mag);
            mul_b = 27'(gyro_gain_ff);
         end
         S_G1: begin
            mul_a = 27'(p1_ff[19:0]);
            mul_b = 27'(dt_ff);
         end
         S_G2: begin
            mul_a = 27'(p1_ff[39:20]);
            mul_b = 27'(dt_ff);
         end
         S_DIV: begin
            mul_a = 27'(div_trial[27:6]);
            mul_b = 27'(DIV_RECIP);
         end
         S_BL0: begin
            mul_a = 27'(blend_weight_ff);
            mul_b = 27'(gest_ff);
         end
         S_BL1: begin
            mul_a = 27'(17'(17'h10000 - {1'b0, blend_weight_ff}));
            mul_b = 27'(cur_t);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign dt_full   = req_time_us - last_time_ff;
   assign sumsq     = acc_ff[31:0] + mul_p[31:0];
   assign sq_trial  = sq_res_ff + sq_bit_ff;
   assign sq_ge     = sq_rem_ff >= sq_trial;
   assign div_trial = {div_rem_ff, acc_ff[63:56]};
   assign div_n     = acc_ff + DIV_ROUND;
   assign q_round   = 45'(div_num_ff) + 45'd128;
   assign q_s       = signed'({1'b0, q_round[44:8]});
   assign step_s    = rate[15] ? -q_s : q_s;
   assign gsum      = 38'(cur_f) + step_s;
   assign bl        = (acc_ff + 64'sd32768) >>> 16;

   // tilt vectors: pitch uses (sqrt(ay^2+az^2), -ax), roll uses (az, ay)
   assign cordic_start = (state_ff == S_TP_START) || (state_ff == S_TR_START);
   assign cordic_x = (state_ff == S_TR_START) ? (25'(az_ff) <<< 8)
                                              : itcf_pkg::angle_type'({1'b0, sq_res_ff[23:0]});
   assign cordic_y = (state_ff == S_TR_START) ? (25'(ay_ff) <<< 8) : -(25'(ax_ff) <<< 8);

   itcf_cordic #(
      .ITERATIONS(CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (cordic_x),
      .y_in  (cordic_y),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         have_prev_ff    <= 1'b0;
         filt_pitch_ff   <= '0;
         filt_roll_ff    <= '0;
         last_time_ff    <= '0;
         blend_weight_ff <= 16'd64225;
         max_gap_ff      <= 24'd100000;
         gyro_gain_ff    <= 24'd256141;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               itcf_pkg::CSR_BLEND_WEIGHT: blend_weight_ff <= csr_wdata[15:0];
               itcf_pkg::CSR_MAX_GAP_US:   max_gap_ff      <= csr_wdata;
               itcf_pkg::CSR_GYRO_GAIN:    gyro_gain_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff <= req_accel_x;
                  ay_ff <= req_accel_y;
                  az_ff <= req_accel_z;
                  gx_ff <= req_gyro_x;
                  gy_ff <= req_gyro_y;
                  dt_ff <= dt_full[23:0];
                  if (!have_prev_ff) begin
                     kind_ff <= itcf_pkg::KIND_FIRST;
                  end else if (dt_full > {8'd0, max_gap_ff}) begin
                     kind_ff <= itcf_pkg::KIND_RELOAD;
                  end else begin
                     kind_ff <= itcf_pkg::KIND_BLEND;
                  end
                  last_time_ff <= req_time_us;
                  have_prev_ff <= 1'b1;
                  state_ff     <= S_SQ0;
               end
            end
            S_SQ0: begin
               acc_ff   <= 64'(mul_p);
               state_ff <= S_SQ1;
            end
            S_SQ1: begin
               sq_rem_ff <= {sumsq, 16'd0};
               sq_res_ff <= '0;
               sq_bit_ff <= 48'd1 << 46;
               cnt_ff    <= '0;
               state_ff  <= S_SQRT;
            end
            S_SQRT: begin
               if (sq_ge) begin
                  sq_rem_ff <= sq_rem_ff - sq_trial;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               cnt_ff    <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(SQRT_STEPS - 1)) begin
                  state_ff <= S_TP_START;
               end
            end
            S_TP_START: state_ff <= S_TP_WAIT;
            S_TP_WAIT: begin
               if (cordic_done) begin
                  tp_ff    <= cordic_angle;
                  state_ff <= S_TR_START;
               end
            end
            S_TR_START: state_ff <= S_TR_WAIT;
            S_TR_WAIT: begin
               if (cordic_done) begin
                  tr_ff    <= cordic_angle;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (kind_ff == itcf_pkg::KIND_BLEND) begin
                  axis_ff  <= 1'b0;
                  state_ff <= S_G0;
               end else begin
                  filt_pitch_ff <= tp_ff;
                  filt_roll_ff  <= tr_ff;
                  state_ff      <= S_DONE;
               end
            end
            S_G0: begin
               p1_ff    <= mul_p[39:0];
               state_ff <= S_G1;
            end
            S_G1: begin
               acc_ff   <= 64'(mul_p);
               state_ff <= S_G2;
            end
            S_G2: begin
               acc_ff   <= acc_ff + (64'(mul_p) <<< 20);
               state_ff <= S_DIV_INIT;
            end
            S_DIV_INIT: begin
               // radix-256 long division, numerator shifted out of acc a byte at a time
               acc_ff     <= signed'(div_n);
               div_rem_ff <= '0;
               div_num_ff <= '0;
               cnt_ff     <= '0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               // digit = ((rem:byte) >> 6) * ceil(2^36/15625) >> 36, exact for this range
               div_digit_ff <= mul_p[43:36];
               state_ff     <= S_DIV_SUB;
            end
            S_DIV_SUB: begin
               div_rem_ff <= 20'(div_trial - 28'(div_digit_ff) * 28'(USEC_PER_SEC));
               div_num_ff <= {div_num_ff[35:0], div_digit_ff};
               acc_ff     <= acc_ff <<< 8;
               cnt_ff     <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(DIV_DIGITS - 1)) begin
                  state_ff <= S_STEP;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_STEP: begin
               gest_ff  <= itcf_pkg::clamp_angle(64'(gsum));
               state_ff <= S_BL0;
            end
            S_BL0: begin
               acc_ff   <= 64'(mul_p);
               state_ff <= S_BL1;
            end
            S_BL1: begin
               acc_ff   <= acc_ff + 64'(mul_p);
               state_ff <= S_BL2;
            end
            S_BL2: begin
               if (!axis_ff) begin
                  filt_pitch_ff <= itcf_pkg::clamp_angle(bl);
                  axis_ff       <= 1'b1;
                  state_ff      <= S_G0;
               end else begin
                  filt_roll_ff <= itcf_pkg::clamp_angle(bl);
                  state_ff     <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_fp_ff    <= out_angle(filt_pitch_ff);
                  rsp_fr_ff    <= out_angle(filt_roll_ff);
                  rsp_tp_ff    <= out_angle(tp_ff);
                  rsp_tr_ff    <= out_angle(tr_ff);
                  rsp_kind_ff  <= kind_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = (state_ff == S_IDLE) && !req_valid;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filt_pitch  = rsp_fp_ff;
   assign rsp_filt_roll   = rsp_fr_ff;
   assign rsp_tilt_pitch  = rsp_tp_ff;
   assign rsp_tilt_roll   = rsp_tr_ff;
   assign rsp_update_kind = rsp_kind_ff;

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken while one is in work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   a_cordic_expected: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == S_TP_WAIT || state_ff == S_TR_WAIT))
      else $error("cordic finished while the sequencer was not waiting");

   a_state_in_range: assert property (@(posedge clock) disable iff (reset)
      filt_pitch_ff <= itcf_pkg::HALF_TURN && filt_pitch_ff >= -itcf_pkg::HALF_TURN &&
      filt_roll_ff <= itcf_pkg::HALF_TURN && filt_roll_ff >= -itcf_pkg::HALF_TURN)
      else $error("filter state beyond half turn");
`endif

endmodule
